### src/sctl_pkg.sv
// Shared types and constants for the sorted composition table lookup.
package sctl_pkg;
  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned MAX_RUN     = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned RUN_W       = $clog2(MAX_RUN + 1);

  localparam logic [15:0] OP_LR     = 16'h2FF0;
  localparam logic [15:0] OP_TB     = 16'h2FF1;
  localparam logic [15:0] HSURR_LO  = 16'hD800;
  localparam logic [15:0] HSURR_HI  = 16'hDBFF;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_QUERY  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BAD_OP   = 3'd2;
  localparam logic [2:0] ST_MATCH    = 3'd3;
  localparam logic [2:0] ST_NO_MATCH = 3'd4;
  localparam logic [2:0] ST_REJECTED = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_QUERY,
    CMD_CLEAR,
    CMD_REPLY
  } cmd_e;

  // classified command from front to back
  typedef struct packed {
    cmd_e        cmd;
    logic [2:0]  status;   // for CMD_REPLY
    logic [32:0] key;
    logic [31:0] ch;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] ch;
    logic        trunc;
    logic        last;
  } res_t;
endpackage

### src/sctl_front.sv
// Front end: accepts input transfers, validates and classifies them.
module sctl_front import sctl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  rec_operator_i,
  input  logic [15:0] op_unit_i,
  input  logic [15:0] left_unit_i,
  input  logic        left_empty_i,
  input  logic [15:0] right_unit_i,
  input  logic        right_empty_i,
  input  logic [31:0] char_in_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);
  localparam int unsigned QD = 2;

  cmd_t       q_mem [QD];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       c;
  logic       push, pop, bad_unit;

  function automatic logic surr(input logic [15:0] u);
    surr = (u >= HSURR_LO) && (u <= HSURR_HI);
  endfunction

  assign bad_unit = left_empty_i || right_empty_i || surr(left_unit_i) || surr(right_unit_i);

  always_comb begin
    c.cmd    = CMD_REPLY;
    c.status = ST_CLEARED;
    c.key    = {1'b0, left_unit_i, right_unit_i};
    c.ch     = char_in_i;
    case (func_i)
      FUNC_INSERT: begin
        if (rec_operator_i > 8'd1) c.status = ST_BAD_OP;
        else begin
          c.cmd = CMD_INSERT;
          c.key[32] = rec_operator_i[0];
        end
      end
      FUNC_QUERY: begin
        if ((op_unit_i != OP_LR && op_unit_i != OP_TB) || bad_unit) c.status = ST_REJECTED;
        else begin
          c.cmd = CMD_QUERY;
          c.key[32] = op_unit_i[0];
        end
      end
      FUNC_CLEAR: c.cmd = CMD_CLEAR;
      default: c.cmd = CMD_REPLY;
    endcase
  end

  assign ready_o     = (cnt_q != 2'(QD));
  // func 3 is dropped without a result
  assign push        = valid_i && ready_o && (func_i != 2'd3);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

### src/sctl_back.sv
// Back end: sorted table memory, binary search, insert shift and run emission.
module sctl_back import sctl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output res_t        res_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_PROBE, S_PWAIT, S_SHIFT, S_RUNRD, S_RUNCHK, S_OUT
  } state_e;

  logic [32:0] keys_mem [TABLE_DEPTH];
  logic [31:0] chars_mem [TABLE_DEPTH];

  state_e      state_q;
  cmd_t        cur_q;
  logic [CNT_W-1:0] count_q, lo_q, hi_q, pos_q;
  logic [RUN_W-1:0] n_q;
  logic [IDX_W-1:0] raddr;
  logic [32:0] rkey_q;
  logic [31:0] rch_q;
  logic        out_full_q;
  res_t        out_q;
  logic [31:0] pend_q;   // last match seen, held until the next read decides last/trunc
  logic        we;
  logic [IDX_W-1:0] waddr;
  logic [32:0] wkey;
  logic [31:0] wch;
  logic [CNT_W-1:0] mid;
  logic        after, below, hit, in_rng;

  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  always_comb begin
    raddr = pos_q[IDX_W-1:0];
    if (state_q == S_PROBE) raddr = mid[IDX_W-1:0];
    else if (state_q == S_OUT) raddr = pos_q[IDX_W-1:0] - IDX_W'(1);
  end

  always_ff @(posedge clk_i) begin
    rkey_q <= keys_mem[raddr];
    rch_q  <= chars_mem[raddr];
    if (we) begin
      keys_mem[waddr]  <= wkey;
      chars_mem[waddr] <= wch;
    end
  end

  assign after  = (rkey_q > cur_q.key) || (rkey_q == cur_q.key && rch_q > cur_q.ch);
  assign below  = rkey_q < cur_q.key;
  assign in_rng = pos_q < count_q;
  assign hit    = in_rng && (rkey_q == cur_q.key);

  // shift step: pos_q is the slot written; entry pos_q-1 was read last cycle
  always_comb begin
    we    = (state_q == S_SHIFT);
    waddr = pos_q[IDX_W-1:0];
    wkey  = rkey_q;
    wch   = rch_q;
    if (pos_q == lo_q) begin
      wkey = cur_q.key;
      wch  = cur_q.ch;
    end
  end

  assign cmd_ready_o = (state_q == S_IDLE) && !out_full_q;
  assign res_valid_o = out_full_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      out_full_q <= 1'b0;
      pend_q     <= '0;
      lo_q <= '0; hi_q <= '0; pos_q <= '0; n_q <= '0;
      cur_q <= '0; out_q <= '0;
    end else begin
      if (out_full_q && res_ready_i) out_full_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i && !out_full_q) begin
            cur_q <= cmd_i;
            lo_q  <= '0;
            hi_q  <= count_q;
            n_q   <= '0;
            case (cmd_i.cmd)
              CMD_CLEAR: begin
                count_q <= '0;
                out_q <= '{ST_CLEARED, 32'd0, 1'b0, 1'b1};
                out_full_q <= 1'b1;
              end
              CMD_REPLY: begin
                out_q <= '{cmd_i.status, 32'd0, 1'b0, 1'b1};
                out_full_q <= 1'b1;
              end
              CMD_INSERT: begin
                if (count_q == CNT_W'(TABLE_DEPTH)) begin
                  out_q <= '{ST_FULL, 32'd0, 1'b0, 1'b1};
                  out_full_q <= 1'b1;
                end else state_q <= S_PROBE;
              end
              default: state_q <= S_PROBE;
            endcase
          end
        end
        S_PROBE: begin
          if (lo_q >= hi_q) begin
            if (cur_q.cmd == CMD_INSERT) begin
              // read from the top down, writing each entry one slot up
              pos_q   <= count_q;
              state_q <= S_OUT;
            end else begin
              pos_q   <= lo_q;
              state_q <= S_RUNRD;
            end
          end else begin
            pos_q   <= mid;
            state_q <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          if (cur_q.cmd == CMD_INSERT) begin
            if (after) hi_q <= pos_q;
            else       lo_q <= pos_q + 1'b1;
          end else begin
            if (below) lo_q <= pos_q + 1'b1;
            else       hi_q <= pos_q;
          end
          state_q <= S_PROBE;
        end
        S_SHIFT: begin
          if (pos_q == lo_q) begin
            count_q <= count_q + 1'b1;
            out_q <= '{ST_INSERTED, 32'd0, 1'b0, 1'b1};
            out_full_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            pos_q   <= pos_q - 1'b1;
            state_q <= S_OUT;
          end
        end
        // read entry pos_q-1 for the next shift step
        S_OUT: state_q <= S_SHIFT;
        S_RUNRD: state_q <= S_RUNCHK;
        S_RUNCHK: begin
          if (!out_full_q || res_ready_i) begin
            if (n_q == '0) begin
              if (hit) begin
                pend_q  <= rch_q;
                n_q     <= n_q + 1'b1;
                pos_q   <= pos_q + 1'b1;
                state_q <= S_RUNRD;
              end else begin
                out_q <= '{ST_NO_MATCH, 32'd0, 1'b0, 1'b1};
                out_full_q <= 1'b1;
                state_q <= S_IDLE;
              end
            end else if (hit && n_q != RUN_W'(MAX_RUN)) begin
              out_q      <= '{ST_MATCH, pend_q, 1'b0, 1'b0};
              out_full_q <= 1'b1;
              pend_q     <= rch_q;
              n_q        <= n_q + 1'b1;
              pos_q      <= pos_q + 1'b1;
              state_q    <= S_RUNRD;
            end else begin
              out_q      <= '{ST_MATCH, pend_q, hit, 1'b1};
              out_full_q <= 1'b1;
              state_q    <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

### src/sorted_composition_table_lookup.sv
// Sorted composition table lookup: front classifier, command queue, table engine.
// Binary search takes up to ceil(log2(count+1)) probes; queries then emit their matches in
// order, and inserts then move each entry above the insert point up one slot.
// The table engine takes one item at a time, only when idle and its result slot is free.
// Reset empties the table (count zero) and clears queue and output; no clearing pass.
module sorted_composition_table_lookup import sctl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func[1:0], rec_operator[9:2], op_unit[25:10], left_unit[41:26], left_empty[42],
  // right_unit[58:43], right_empty[59], char_in[91:60], zeros[95:92]
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], char_out[34:3], run_truncated[35], zeros[39:36]
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  sctl_front u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .func_i(s_axis_tdata[1:0]), .rec_operator_i(s_axis_tdata[9:2]),
    .op_unit_i(s_axis_tdata[25:10]), .left_unit_i(s_axis_tdata[41:26]),
    .left_empty_i(s_axis_tdata[42]), .right_unit_i(s_axis_tdata[58:43]),
    .right_empty_i(s_axis_tdata[59]), .char_in_i(s_axis_tdata[91:60]),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  sctl_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {4'd0, res.trunc, res.ch, res.status};
  assign m_axis_tlast = res.last;
endmodule
